FILE: hdl/tpg_pkg.sv
// tpg_pkg: shared constants and types for the trapezoidal profile generator
// no dependencies
`timescale 1ns / 1ps

package tpg_pkg;

  localparam int POS_FRAC_BITS_DEF = 16;

  localparam logic [19:0] USEC_PER_S = 20'd1000000;
  localparam logic [40:0] TWO_USEC_SQ = 41'd2000000000000;

  localparam logic [15:0] VEL_RESET = 16'd1000;
  localparam logic [15:0] ACC_RESET = 16'd2000;

  typedef enum logic [2:0] {
    PH_NONE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [0:0] {
    REG_MAX_VEL = 1'b0,
    REG_MAX_ACC = 1'b1
  } cfg_reg_t;

endpackage

FILE: hdl/tpg_sqrt.sv
// tpg_sqrt: pipelined integer square root, one result bit per stage
// standalone, carries an opaque payload alongside
`timescale 1ns / 1ps

module tpg_sqrt #(
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [63:0]      in_num,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_vld,
  output logic [31:0]      out_root,
  output logic [PAY_W-1:0] out_pay
);

  localparam int STAGES = 32;

  logic [STAGES:0] vld_r;
  logic [33:0]      rem_r  [0:STAGES];
  logic [31:0]      root_r [0:STAGES];
  logic [63:0]      sh_r   [0:STAGES];
  logic [PAY_W-1:0] pay_r  [0:STAGES];
  logic [33:0]      rem_nxt  [0:STAGES-1];
  logic [31:0]      root_nxt [0:STAGES-1];
  logic [35:0]      rem_ext  [0:STAGES-1];
  logic [35:0]      trial    [0:STAGES-1];
  logic             ge       [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    assign rem_ext[i]  = {rem_r[i], sh_r[i][63:62]};
    assign trial[i]    = {2'b00, root_r[i], 2'b01};
    assign ge[i]       = (rem_ext[i] >= trial[i]);
    assign rem_nxt[i]  = ge[i] ? 34'(rem_ext[i] - trial[i]) : rem_ext[i][33:0];
    assign root_nxt[i] = {root_r[i][30:0], ge[i]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    sh_r[0]   <= in_num;
    pay_r[0]  <= in_pay;
    for (int i = 0; i < STAGES; i++) begin
      rem_r[i+1]  <= rem_nxt[i];
      root_r[i+1] <= root_nxt[i];
      sh_r[i+1]   <= {sh_r[i][61:0], 2'b00};
      pay_r[i+1]  <= pay_r[i];
    end
  end

  assign out_vld  = vld_r[STAGES];
  assign out_root = root_r[STAGES];
  assign out_pay  = pay_r[STAGES];

endmodule

FILE: hdl/tpg_div.sv
// tpg_div: pipelined restoring divider, one quotient bit per stage
// standalone; caller keeps the quotient below 2**QUO_W
`timescale 1ns / 1ps

module tpg_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int QUO_W = 32,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [PAY_W-1:0] in_pay,
  output logic             out_vld,
  output logic [QUO_W-1:0] out_quo,
  output logic [PAY_W-1:0] out_pay
);

  localparam int REM_W = DEN_W + 1;

  logic [QUO_W:0]   vld_r;
  logic [DEN_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] sh_r  [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic [PAY_W-1:0] pay_r [0:QUO_W];
  logic [DEN_W-1:0] rem_nxt [0:QUO_W-1];
  logic [QUO_W-1:0] sh_nxt  [0:QUO_W-1];
  logic [REM_W-1:0] trial   [0:QUO_W-1];
  logic             ge      [0:QUO_W-1];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    assign trial[i]   = {rem_r[i], sh_r[i][QUO_W-1]};
    assign ge[i]      = (trial[i] >= {1'b0, den_r[i]});
    assign rem_nxt[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, den_r[i]}) : trial[i][DEN_W-1:0];
    assign sh_nxt[i]  = {sh_r[i][QUO_W-2:0], ge[i]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QUO_W-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= DEN_W'(in_num[NUM_W-1:QUO_W]);
    sh_r[0]  <= in_num[QUO_W-1:0];
    den_r[0] <= in_den;
    pay_r[0] <= in_pay;
    for (int i = 0; i < QUO_W; i++) begin
      rem_r[i+1] <= rem_nxt[i];
      sh_r[i+1]  <= sh_nxt[i];
      den_r[i+1] <= den_r[i];
      pay_r[i+1] <= pay_r[i];
    end
  end

  assign out_vld = vld_r[QUO_W];
  assign out_quo = sh_r[QUO_W];
  assign out_pay = pay_r[QUO_W];

endmodule

FILE: hdl/trapezoidal_profile_generator_top.sv
// trapezoidal_profile_generator_top: per-sample trapezoidal/triangular motion profile
// uses tpg_pkg, tpg_sqrt and tpg_div
`timescale 1ns / 1ps

// Evaluates one move sample per clock: a start pulse with start/end position and elapsed
// time yields position, velocity, acceleration and phase on a one-cycle out_valid strobe;
// busy is always low and a new start may follow every cycle. Most of the pipeline depth
// lies in the 32-stage square root and the POS_FRAC_BITS + 34 stage dividers. The receiver
// cannot stall, so every strobe must be captured when it occurs. Configuration writes must
// happen only while no sample is in flight.
module trapezoidal_profile_generator_top #(
  parameter int POS_FRAC_BITS = tpg_pkg::POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_start_position,
  input  logic signed [15:0] in_end_position,
  input  logic [31:0]        in_elapsed_us,
  output logic               out_valid,
  output logic signed [32:0] out_desired_position,
  output logic signed [24:0] out_desired_velocity,
  output logic signed [16:0] out_desired_acceleration,
  output logic [2:0]         out_phase,
  output logic               out_triangular
);

  import tpg_pkg::*;

  localparam int F      = POS_FRAC_BITS;
  localparam int QW     = F + 34;
  localparam int ONW    = F + 110;
  localparam int VNW    = F + 71;
  localparam int POS_W  = F + 40;
  localparam int LAT    = QW + 42;

  typedef struct packed {
    logic signed [15:0] sp;
    logic signed [15:0] ep;
    logic [15:0]        dlen;
    logic               neg;
    logic               nz;
  } geo_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] vm;
    logic [15:0] am;
    logic [31:0] t;
    logic [47:0] at;
    logic [47:0] vt;
    logic [31:0] vv;
    logic [31:0] asp;
    logic [35:0] ve;
    logic [35:0] se;
  } p1_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] vm;
    logic [15:0] am;
    logic [47:0] at;
    logic [35:0] ve;
    logic        trian;
    logic        k1t;
    logic        k2t;
    logic [63:0] atv;
    logic [51:0] vve;
    logic [51:0] ase;
    logic [47:0] vva;
    logic [35:0] ae;
    logic [63:0] avt;
    logic [55:0] att_lo;
    logic [55:0] att_hi;
    logic [31:0] asp;
  } p2_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] vm;
    logic [15:0] am;
    logic [47:0] at;
    logic [35:0] ve;
    logic        trian;
    logic        k1t;
    logic        k2t;
    logic        k3t;
    logic [53:0] nnt;
    logic [67:0] vvae;
    logic [55:0] aee;
    logic [79:0] att;
    logic [65:0] ncr;
    logic [35:0] ae;
  } p3_t;

  typedef struct packed {
    p3_t         b;
    logic [31:0] root;
    logic [51:0] pe;
    logic [87:0] vvaee;
  } p4_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] vm;
    logic [15:0] am;
    logic        trian;
    phase_t      kind;
    logic [53:0] nn;
    logic [53:0] nv;
    logic [35:0] dv;
    logic [79:0] att;
    logic [65:0] ncr;
    logic [35:0] ae;
    logic [87:0] vvaee;
    logic [55:0] aee;
  } p5_t;

  typedef struct packed {
    geo_t         geo;
    logic [15:0]  vm;
    logic [15:0]  am;
    logic         trian;
    phase_t       kind;
    logic [53:0]  ll;
    logic [53:0]  lh;
    logic [53:0]  hh;
    logic [53:0]  nv;
    logic [35:0]  dv;
    logic [79:0]  offn_pre;
    logic [88:0]  offd;
  } p6_t;

  typedef struct packed {
    geo_t         geo;
    logic [15:0]  vm;
    logic [15:0]  am;
    logic         trian;
    phase_t       kind;
    logic [107:0] offn;
    logic [88:0]  offd;
    logic [53:0]  nv;
    logic [35:0]  dv;
  } p7_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] vm;
    logic [15:0] am;
  } tail_a_t;

  typedef struct packed {
    phase_t kind;
    logic   trian;
  } tail_b_t;

  typedef struct packed {
    geo_t        geo;
    logic [15:0] am;
    phase_t      kind;
    logic        trian;
    logic [QW-1:0] off;
    logic [24:0] mag;
  } p9_t;

  logic [15:0] vmax_r, amax_r;

  logic p1_v_r, p2_v_r, p4_v_r, p5_v_r, p6_v_r, p7_v_r, p9_v_r;
  p1_t  p1_r, p1_nxt;
  p2_t  p2_r, p2_nxt;
  p3_t  p3_nxt;
  p4_t  p4_r, p4_nxt;
  p5_t  p5_r, p5_nxt;
  p6_t  p6_r, p6_nxt;
  p7_t  p7_r, p7_nxt;
  p9_t  p9_r, p9_nxt;

  logic        sq_vld;
  logic [31:0] sq_root;
  p3_t         sq_pay;

  logic [ONW-1:0] off_num;
  logic [89:0]    off_den;
  logic [VNW-1:0] vel_num;
  logic [37:0]    vel_den;
  logic           off_vld, vel_vld;
  logic [QW-1:0]  off_quo, vel_quo;
  tail_a_t        off_pay_in, off_pay;
  tail_b_t        vel_pay_in, vel_pay;

  logic                     out_vld_r;
  logic signed [32:0]       out_pos_r, out_pos_nxt;
  logic signed [24:0]       out_vel_r, out_vel_nxt;
  logic signed [16:0]       out_acc_r, out_acc_nxt;
  phase_t                   out_ph_r, out_ph_nxt;
  logic                     out_tri_r, out_tri_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_r <= VEL_RESET;
      amax_r <= ACC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_VEL: vmax_r <= cfg_data;
        REG_MAX_ACC: amax_r <= cfg_data;
      endcase
    end
  end

  // stage 1: distance, direction and first products
  always_comb begin
    logic signed [16:0] diff;
    logic [15:0]        vm, am;
    diff = 17'(in_end_position) - 17'(in_start_position);
    vm   = (vmax_r == '0) ? 16'd1 : vmax_r;
    am   = (amax_r == '0) ? 16'd1 : amax_r;
    p1_nxt.geo.sp   = in_start_position;
    p1_nxt.geo.ep   = in_end_position;
    p1_nxt.geo.neg  = diff[16];
    p1_nxt.geo.nz   = (diff != '0);
    p1_nxt.geo.dlen = diff[16] ? 16'(-diff) : diff[15:0];
    p1_nxt.vm  = vm;
    p1_nxt.am  = am;
    p1_nxt.t   = in_elapsed_us;
    p1_nxt.at  = 48'(am) * 48'(in_elapsed_us);
    p1_nxt.vt  = 48'(vm) * 48'(in_elapsed_us);
    p1_nxt.vv  = 32'(vm) * 32'(vm);
    p1_nxt.asp = 32'(am) * 32'(p1_nxt.geo.dlen);
    p1_nxt.ve  = 36'(vm) * 36'(USEC_PER_S);
    p1_nxt.se  = 36'(p1_nxt.geo.dlen) * 36'(USEC_PER_S);
  end

  // stage 2: shape test and second products
  always_comb begin
    p2_nxt.geo    = p1_r.geo;
    p2_nxt.vm     = p1_r.vm;
    p2_nxt.am     = p1_r.am;
    p2_nxt.at     = p1_r.at;
    p2_nxt.ve     = p1_r.ve;
    p2_nxt.trian  = (p1_r.vv >= p1_r.asp);
    p2_nxt.k1t    = (p1_r.at <= 48'(p1_r.ve));
    p2_nxt.k2t    = (p1_r.vt < 48'(p1_r.se));
    p2_nxt.atv    = 64'(p1_r.at) * 64'(p1_r.vm);
    p2_nxt.vve    = 52'(p1_r.vv) * 52'(USEC_PER_S);
    p2_nxt.ase    = 52'(p1_r.asp) * 52'(USEC_PER_S);
    p2_nxt.vva    = 48'(p1_r.vv) * 48'(p1_r.am);
    p2_nxt.ae     = 36'(p1_r.am) * 36'(USEC_PER_S);
    p2_nxt.avt    = 64'(p1_r.vt) * 64'(p1_r.am);
    p2_nxt.att_lo = 56'(p1_r.at[23:0]) * 56'(p1_r.t);
    p2_nxt.att_hi = 56'(p1_r.at[47:24]) * 56'(p1_r.t);
    p2_nxt.asp    = p1_r.asp;
  end

  // stage 3: trapezoid decel test, sums; enters the square root with its payload
  always_comb begin
    logic [52:0] sum;
    sum = 53'(p2_r.vve) + 53'(p2_r.ase);
    p3_nxt.geo   = p2_r.geo;
    p3_nxt.vm    = p2_r.vm;
    p3_nxt.am    = p2_r.am;
    p3_nxt.at    = p2_r.at;
    p3_nxt.ve    = p2_r.ve;
    p3_nxt.trian = p2_r.trian;
    p3_nxt.k1t   = p2_r.k1t;
    p3_nxt.k2t   = p2_r.k2t;
    p3_nxt.k3t   = (p2_r.atv <= 64'(sum));
    p3_nxt.nnt   = 54'(64'(sum) - p2_r.atv);
    p3_nxt.vvae  = 68'(p2_r.vva) * 68'(USEC_PER_S);
    p3_nxt.aee   = 56'(p2_r.ae) * 56'(USEC_PER_S);
    p3_nxt.att   = 80'(p2_r.att_lo) + (80'(p2_r.att_hi) << 24);
    p3_nxt.ncr   = (66'(p2_r.avt) << 1) - 66'(p2_r.vve);
    p3_nxt.ae    = p2_r.ae;
  end

  tpg_sqrt #(
    .PAY_W ($bits(p3_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p2_v_r),
    .in_num   ({p2_r.asp, 32'd0}),
    .in_pay   (p3_nxt),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_pay  (sq_pay)
  );

  // stage 4: peak velocity times one second
  always_comb begin
    p4_nxt.b     = sq_pay;
    p4_nxt.root  = sq_root;
    p4_nxt.pe    = 52'(sq_root) * 52'(USEC_PER_S);
    p4_nxt.vvaee = 88'(sq_pay.vvae) * 88'(USEC_PER_S);
  end

  // stage 5: phase classification
  always_comb begin
    logic [52:0] pe2m1;
    logic        k1, k3;
    logic [63:0] nn_tri;
    pe2m1  = (53'(p4_r.pe) << 1) - 53'd1;
    k1     = (p4_r.b.at <= 48'(p4_r.pe[51:16]));
    k3     = (p4_r.root != '0) && (p4_r.b.at <= 48'(pe2m1[52:16]));
    nn_tri = (64'(p4_r.pe) << 1) - (64'(p4_r.b.at) << 16);
    p5_nxt.geo   = p4_r.b.geo;
    p5_nxt.vm    = p4_r.b.vm;
    p5_nxt.am    = p4_r.b.am;
    p5_nxt.trian = p4_r.b.trian;
    p5_nxt.att   = p4_r.b.att;
    p5_nxt.ncr   = p4_r.b.ncr;
    p5_nxt.ae    = p4_r.b.ae;
    p5_nxt.vvaee = p4_r.vvaee;
    p5_nxt.aee   = p4_r.b.aee;
    if (p4_r.b.trian) begin
      p5_nxt.nn = nn_tri[53:0];
      p5_nxt.dv = 36'(USEC_PER_S) << 16;
      priority if (k1) p5_nxt.kind = PH_ACCEL;
      else if (k3)     p5_nxt.kind = PH_DECEL;
      else             p5_nxt.kind = PH_DONE;
    end else begin
      p5_nxt.nn = p4_r.b.nnt;
      p5_nxt.dv = p4_r.b.ve;
      priority if (p4_r.b.k1t) p5_nxt.kind = PH_ACCEL;
      else if (p4_r.b.k2t)     p5_nxt.kind = PH_CRUISE;
      else if (p4_r.b.k3t)     p5_nxt.kind = PH_DECEL;
      else                     p5_nxt.kind = PH_DONE;
    end
    if (p5_nxt.kind == PH_ACCEL) begin
      p5_nxt.nv = 54'(p4_r.b.at);
      p5_nxt.dv = 36'(USEC_PER_S);
    end else begin
      p5_nxt.nv = p5_nxt.nn;
    end
  end

  // stage 6: square partials and denominator select
  always_comb begin
    p6_nxt.geo   = p5_r.geo;
    p6_nxt.vm    = p5_r.vm;
    p6_nxt.am    = p5_r.am;
    p6_nxt.trian = p5_r.trian;
    p6_nxt.kind  = p5_r.kind;
    p6_nxt.ll    = 54'(p5_r.nn[26:0]) * 54'(p5_r.nn[26:0]);
    p6_nxt.lh    = 54'(p5_r.nn[26:0]) * 54'(p5_r.nn[53:27]);
    p6_nxt.hh    = 54'(p5_r.nn[53:27]) * 54'(p5_r.nn[53:27]);
    p6_nxt.nv    = p5_r.nv;
    p6_nxt.dv    = p5_r.dv;
    unique case (p5_r.kind)
      PH_ACCEL: begin
        p6_nxt.offn_pre = p5_r.att;
        p6_nxt.offd     = 89'(TWO_USEC_SQ);
      end
      PH_CRUISE: begin
        p6_nxt.offn_pre = 80'(p5_r.ncr);
        p6_nxt.offd     = 89'(p5_r.ae) << 1;
      end
      PH_DECEL: begin
        p6_nxt.offn_pre = '0;
        p6_nxt.offd     = p5_r.trian ? (89'(p5_r.aee) << 33) : (89'(p5_r.vvaee) << 1);
      end
      default: begin
        p6_nxt.offn_pre = '0;
        p6_nxt.offd     = 89'd1;
      end
    endcase
  end

  // stage 7: square sum
  always_comb begin
    logic [107:0] nsq;
    nsq = 108'(p6_r.ll) + (108'(p6_r.lh) << 28) + (108'(p6_r.hh) << 54);
    p7_nxt.geo   = p6_r.geo;
    p7_nxt.vm    = p6_r.vm;
    p7_nxt.am    = p6_r.am;
    p7_nxt.trian = p6_r.trian;
    p7_nxt.kind  = p6_r.kind;
    p7_nxt.offn  = (p6_r.kind == PH_DECEL) ? nsq : 108'(p6_r.offn_pre);
    p7_nxt.offd  = p6_r.offd;
    p7_nxt.nv    = p6_r.nv;
    p7_nxt.dv    = p6_r.dv;
  end

  // rounded quotients: floor((n * 2**(k+1) + d) / (2 * d))
  assign off_num = (ONW'(p7_r.offn) << (F + 1)) + ONW'(p7_r.offd);
  assign off_den = 90'(p7_r.offd) << 1;
  assign vel_num = (VNW'(p7_r.nv) << 9) + VNW'(p7_r.dv);
  assign vel_den = 38'(p7_r.dv) << 1;

  assign off_pay_in = '{geo: p7_r.geo, vm: p7_r.vm, am: p7_r.am};
  assign vel_pay_in = '{kind: p7_r.kind, trian: p7_r.trian};

  tpg_div #(
    .NUM_W (ONW),
    .DEN_W (90),
    .QUO_W (QW),
    .PAY_W ($bits(tail_a_t))
  ) u_off_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p7_v_r),
    .in_num  (off_num),
    .in_den  (off_den),
    .in_pay  (off_pay_in),
    .out_vld (off_vld),
    .out_quo (off_quo),
    .out_pay (off_pay)
  );

  tpg_div #(
    .NUM_W (VNW),
    .DEN_W (38),
    .QUO_W (QW),
    .PAY_W ($bits(tail_b_t))
  ) u_vel_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p7_v_r),
    .in_num  (vel_num),
    .in_den  (vel_den),
    .in_pay  (vel_pay_in),
    .out_vld (vel_vld),
    .out_quo (vel_quo),
    .out_pay (vel_pay)
  );

  // stage 9: offset from the end for deceleration, velocity magnitude
  always_comb begin
    logic [QW-1:0] full;
    full = QW'(off_pay.geo.dlen) << F;
    p9_nxt.geo   = off_pay.geo;
    p9_nxt.am    = off_pay.am;
    p9_nxt.kind  = vel_pay.kind;
    p9_nxt.trian = vel_pay.trian;
    if (vel_pay.kind == PH_DECEL) begin
      p9_nxt.off = (off_quo > full) ? '0 : full - off_quo;
    end else begin
      p9_nxt.off = off_quo;
    end
    p9_nxt.mag = (vel_pay.kind == PH_CRUISE) ? (25'(off_pay.vm) << 8) : vel_quo[24:0];
  end

  // output stage
  always_comb begin
    logic signed [POS_W-1:0] spos, epos, offs, pos;
    logic signed [16:0]      acc;
    spos = POS_W'(p9_r.geo.sp) <<< F;
    epos = POS_W'(p9_r.geo.ep) <<< F;
    offs = POS_W'(p9_r.off);
    pos  = p9_r.geo.neg ? spos - offs : spos + offs;
    unique case (p9_r.kind)
      PH_ACCEL: acc = 17'({1'b0, p9_r.am});
      PH_DECEL: acc = -17'({1'b0, p9_r.am});
      default:  acc = '0;
    endcase
    if (!p9_r.geo.nz) begin
      out_pos_nxt = epos[32:0];
      out_vel_nxt = '0;
      out_acc_nxt = '0;
      out_ph_nxt  = PH_NONE;
      out_tri_nxt = 1'b0;
    end else if (p9_r.kind == PH_DONE) begin
      out_pos_nxt = epos[32:0];
      out_vel_nxt = '0;
      out_acc_nxt = '0;
      out_ph_nxt  = PH_DONE;
      out_tri_nxt = p9_r.trian;
    end else begin
      out_pos_nxt = pos[32:0];
      out_vel_nxt = p9_r.geo.neg ? -p9_r.mag : p9_r.mag;
      out_acc_nxt = p9_r.geo.neg ? -acc : acc;
      out_ph_nxt  = p9_r.kind;
      out_tri_nxt = p9_r.trian;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      p4_v_r    <= 1'b0;
      p5_v_r    <= 1'b0;
      p6_v_r    <= 1'b0;
      p7_v_r    <= 1'b0;
      p9_v_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p1_v_r    <= start && !busy;
      p2_v_r    <= p1_v_r;
      p4_v_r    <= sq_vld;
      p5_v_r    <= p4_v_r;
      p6_v_r    <= p5_v_r;
      p7_v_r    <= p6_v_r;
      p9_v_r    <= off_vld && vel_vld;
      out_vld_r <= p9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    p4_r      <= p4_nxt;
    p5_r      <= p5_nxt;
    p6_r      <= p6_nxt;
    p7_r      <= p7_nxt;
    p9_r      <= p9_nxt;
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
    out_acc_r <= out_acc_nxt;
    out_ph_r  <= out_ph_nxt;
    out_tri_r <= out_tri_nxt;
  end

  assign busy                     = 1'b0;
  assign out_valid                = out_vld_r;
  assign out_desired_position     = out_pos_r;
  assign out_desired_velocity     = out_vel_r;
  assign out_desired_acceleration = out_acc_r;
  assign out_phase                = out_ph_r;
  assign out_triangular           = out_tri_r;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    off_vld == vel_vld)
    else $error("divider valids out of step");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing at fixed latency");

  a_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_NONE) |->
      (out_desired_velocity == '0 && out_desired_acceleration == '0 && !out_triangular))
    else $error("zero-length move with motion");

  a_done_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_DONE) |->
      (out_desired_velocity == '0 && out_desired_acceleration == '0))
    else $error("finished move with motion");

  a_cruise_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_CRUISE) |-> (out_desired_acceleration == '0))
    else $error("cruise with acceleration");

endmodule
